// ===== rtl/core/posting_block_skip_index_core_macros.svh =====
// ----------------------------------------------------------------------------
// posting_block_skip_index_core_macros
// Assertion helpers for the skip index core.
// ----------------------------------------------------------------------------
`ifndef POSTING_BLOCK_SKIP_INDEX_CORE_MACROS_SVH
`define POSTING_BLOCK_SKIP_INDEX_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PBSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsi_pkg
// Shared constants and codes of the posting block skip index.
// ----------------------------------------------------------------------------
package pbsi_pkg;
    localparam int ENTRIES_PER_NODE_DEF = 8;
    localparam int NODES_DEF            = 256;
    localparam int DOC_W                = 31;
    localparam int OP_W                 = 3;
    localparam int STATUS_W             = 2;
    localparam int OFS_W                = 16;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 3'd2;
    localparam logic [OP_W-1:0] OP_SKIP  = 3'd3;
    localparam logic [OP_W-1:0] OP_LAST  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ASC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd3;
endpackage

// ===== rtl/core/pbsi_ram.sv =====
// ----------------------------------------------------------------------------
// pbsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/posting_block_skip_index_core.sv =====
// ----------------------------------------------------------------------------
// posting_block_skip_index_core
// Ascending document store in base/offset nodes with a read cursor.
// ----------------------------------------------------------------------------
// Zero add, empty-store and undefined cases answer from idle; add, first and last
// read node RAMs. Next walks node by node, reading an offset for a non-base entry.
// Skip answers from the cursor node when it settles it, else scans node bases, then
// compares the offsets of the last node whose base does not pass the target.
// One transaction at a time; o_valid strobes one cycle, no stall. Sync active-low reset
// empties the store; RAMs need no clearing.
module posting_block_skip_index_core
    import pbsi_pkg::*;
#(
    parameter int ENTRIES_PER_NODE = ENTRIES_PER_NODE_DEF,
    parameter int NODES            = NODES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DOC_W-1:0]    i_docno,
    output logic                o_valid,
    output logic [DOC_W-1:0]    o_found_doc,
    output logic [STATUS_W-1:0] o_status
);
    localparam int OFS  = ENTRIES_PER_NODE - 1;
    localparam int CW   = $clog2(NODES + 1);
    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int FW   = $clog2(ENTRIES_PER_NODE);
    localparam int ODEP = NODES * OFS;
    localparam int OAW  = (ODEP > 1) ? $clog2(ODEP) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_W   = 4'd1;
    localparam logic [3:0] S_FIRST_W = 4'd2;
    localparam logic [3:0] S_LAST_W  = 4'd3;
    localparam logic [3:0] S_LAST_OW = 4'd4;
    localparam logic [3:0] S_NX_CHK  = 4'd5;
    localparam logic [3:0] S_NX_W    = 4'd6;
    localparam logic [3:0] S_NX_OW   = 4'd7;
    localparam logic [3:0] S_SK_W0   = 4'd8;
    localparam logic [3:0] S_SK_SCAN = 4'd9;
    localparam logic [3:0] S_SK_SW   = 4'd10;
    localparam logic [3:0] S_SK_END  = 4'd11;
    localparam logic [3:0] S_SK_OFS  = 4'd12;
    localparam logic [3:0] S_SK_OW   = 4'd13;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_node_count, n_node_count;
    logic [CW-1:0]       r_cursor_node, n_cursor_node;
    logic [FW-1:0]       r_cursor_entry, n_cursor_entry;
    logic [DOC_W-1:0]    r_doc, n_doc;
    logic [CW-1:0]       r_di, n_di;
    logic [FW-1:0]       r_ce, n_ce;
    logic [FW-1:0]       r_i, n_i;
    logic [DOC_W-1:0]    r_prevbase, n_prevbase;
    logic [FW-1:0]       r_prevfill, n_prevfill;
    logic [DOC_W-1:0]    r_nextbase, n_nextbase;
    logic                r_valid, n_valid;
    logic [DOC_W-1:0]    r_found, n_found;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                node_we, ofs_we;
    logic [NW-1:0]       node_wa, node_ra;
    logic [DOC_W-1:0]    base_wd, base_rd;
    logic [FW-1:0]       fill_wd, fill_rd;
    logic [OAW-1:0]      ofs_wa, ofs_ra;
    logic [OFS_W-1:0]    ofs_wd, ofs_rd;

    logic [CW-1:0]       last_cnt;
    logic [NW-1:0]       last_node;
    logic [NW-1:0]       prev_node;
    logic [DOC_W-1:0]    add_diff;
    logic [DOC_W-1:0]    skip_diff;
    logic [FW:0]         entry_inc;

    pbsi_ram #(.WIDTH(DOC_W), .DEPTH(NODES)) u_base (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(base_wd),
        .i_raddr(node_ra), .o_rdata(base_rd)
    );

    pbsi_ram #(.WIDTH(FW), .DEPTH(NODES)) u_fill (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(fill_wd),
        .i_raddr(node_ra), .o_rdata(fill_rd)
    );

    pbsi_ram #(.WIDTH(OFS_W), .DEPTH(ODEP)) u_ofs (
        .i_clk(i_clk), .i_we(ofs_we), .i_waddr(ofs_wa), .i_wdata(ofs_wd),
        .i_raddr(ofs_ra), .o_rdata(ofs_rd)
    );

    assign last_cnt  = CW'(r_node_count - 1'b1);
    assign last_node = last_cnt[NW-1:0];
    assign prev_node = NW'(r_di - 1'b1);
    assign add_diff  = r_doc - base_rd;
    assign skip_diff = r_doc - r_prevbase;
    assign entry_inc = {1'b0, r_cursor_entry} + 1'b1;

    always_comb begin
        n_state        = r_state;
        n_node_count   = r_node_count;
        n_cursor_node  = r_cursor_node;
        n_cursor_entry = r_cursor_entry;
        n_doc          = r_doc;
        n_di           = r_di;
        n_ce           = r_ce;
        n_i            = r_i;
        n_prevbase     = r_prevbase;
        n_prevfill     = r_prevfill;
        n_nextbase     = r_nextbase;
        n_valid        = 1'b0;
        n_found        = r_found;
        n_status       = r_status;
        node_we        = 1'b0;
        node_wa        = r_node_count[NW-1:0];
        base_wd        = r_doc;
        fill_wd        = '0;
        ofs_we         = 1'b0;
        ofs_wa         = OAW'(last_node * OFS + fill_rd);
        ofs_wd         = add_diff[OFS_W-1:0];
        node_ra        = '0;
        ofs_ra         = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_doc    = i_docno;
                    n_found  = '0;
                    n_status = ST_OK;
                    case (i_operation)
                        OP_ADD: begin
                            if (i_docno == '0) begin
                                n_status = ST_ZERO;
                                n_valid  = 1'b1;
                            end else if (r_node_count == '0) begin
                                // empty store: open node 0 directly
                                node_we      = 1'b1;
                                base_wd      = i_docno;
                                n_node_count = CW'(r_node_count + 1'b1);
                                n_found      = i_docno;
                                n_valid      = 1'b1;
                            end else begin
                                node_ra = last_node;
                                n_state = S_ADD_W;
                            end
                        end
                        OP_FIRST: begin
                            n_cursor_node  = '0;
                            n_cursor_entry = '0;
                            if (r_node_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_FIRST_W;
                            end
                        end
                        OP_NEXT: begin
                            if (entry_inc >= (FW+1)'(ENTRIES_PER_NODE)) begin
                                n_ce = '0;
                                n_di = CW'(r_cursor_node + 1'b1);
                            end else begin
                                n_ce = entry_inc[FW-1:0];
                                n_di = r_cursor_node;
                            end
                            n_state = S_NX_CHK;
                        end
                        OP_SKIP: begin
                            if (r_node_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                node_ra = r_cursor_node[NW-1:0];
                                n_state = S_SK_W0;
                            end
                        end
                        OP_LAST: begin
                            if (r_node_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                node_ra = last_node;
                                n_state = S_LAST_W;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD_W: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                if (r_doc <= base_rd) begin
                    n_status = ST_NOT_ASC;
                end else if (add_diff < DOC_W'(65535) && fill_rd < FW'(OFS)) begin
                    ofs_we  = 1'b1;
                    node_we = 1'b1;
                    node_wa = last_node;
                    base_wd = base_rd;
                    fill_wd = FW'(fill_rd + 1'b1);
                    n_found = r_doc;
                end else if (r_node_count >= CW'(NODES)) begin
                    n_status = ST_FULL;
                end else begin
                    node_we      = 1'b1;
                    n_node_count = CW'(r_node_count + 1'b1);
                    n_found      = r_doc;
                end
            end
            S_FIRST_W: begin
                n_found = base_rd;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_LAST_W: begin
                if (fill_rd == '0) begin
                    n_found = base_rd;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_prevbase = base_rd;
                    ofs_ra     = OAW'(last_node * OFS + fill_rd - 1);
                    n_state    = S_LAST_OW;
                end
            end
            S_LAST_OW: begin
                n_found = r_prevbase + DOC_W'(ofs_rd);
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_NX_CHK: begin
                if (r_di >= r_node_count) begin
                    // past the end: rewind to the first entry
                    n_cursor_node  = '0;
                    n_cursor_entry = '0;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    node_ra = r_di[NW-1:0];
                    n_state = S_NX_W;
                end
            end
            S_NX_W: begin
                if (r_ce == '0) begin
                    n_cursor_node  = r_di;
                    n_cursor_entry = '0;
                    n_found        = base_rd;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else if (FW'(r_ce - 1'b1) < fill_rd) begin
                    n_prevbase = base_rd;
                    ofs_ra     = OAW'(r_di[NW-1:0] * OFS + r_ce - 1);
                    n_state    = S_NX_OW;
                end else begin
                    n_ce    = '0;
                    n_di    = CW'(r_di + 1'b1);
                    n_state = S_NX_CHK;
                end
            end
            S_NX_OW: begin
                n_cursor_node  = r_di;
                n_cursor_entry = r_ce;
                n_found        = r_prevbase + DOC_W'(ofs_rd);
                n_valid        = 1'b1;
                n_state        = S_IDLE;
            end
            S_SK_W0: begin
                if (base_rd >= r_doc) begin
                    if (base_rd == r_doc || r_cursor_node == '0) begin
                        n_cursor_entry = '0;
                        n_found        = base_rd;
                        n_valid        = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_di    = '0;
                        n_state = S_SK_SCAN;
                    end
                end else begin
                    n_di    = r_cursor_node;
                    n_state = S_SK_SCAN;
                end
            end
            S_SK_SCAN: begin
                if (r_di < r_node_count) begin
                    node_ra = r_di[NW-1:0];
                    n_state = S_SK_SW;
                end else begin
                    n_state = S_SK_END;
                end
            end
            S_SK_SW: begin
                if (base_rd <= r_doc) begin
                    n_prevbase = base_rd;
                    n_prevfill = fill_rd;
                    n_di       = CW'(r_di + 1'b1);
                    n_state    = S_SK_SCAN;
                end else begin
                    n_nextbase = base_rd;
                    n_state    = S_SK_END;
                end
            end
            S_SK_END: begin
                n_i = '0;
                if (r_di == '0) begin
                    n_cursor_node  = '0;
                    n_cursor_entry = '0;
                    n_found        = r_nextbase;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else if (r_doc == r_prevbase) begin
                    n_cursor_node  = CW'(r_di - 1'b1);
                    n_cursor_entry = '0;
                    n_found        = r_doc;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_SK_OFS;
                end
            end
            S_SK_OFS: begin
                if (r_i < r_prevfill) begin
                    ofs_ra  = OAW'(prev_node * OFS + r_i);
                    n_state = S_SK_OW;
                end else begin
                    // no offset reaches the target: fall to the next node base, if there is one
                    if (r_di < r_node_count) begin
                        n_cursor_node  = r_di;
                        n_cursor_entry = '0;
                        n_found        = r_nextbase;
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SK_OW: begin
                if (skip_diff > DOC_W'(ofs_rd)) begin
                    n_i     = FW'(r_i + 1'b1);
                    n_state = S_SK_OFS;
                end else begin
                    n_cursor_node  = CW'(r_di - 1'b1);
                    n_cursor_entry = FW'(r_i + 1'b1);
                    n_found        = r_prevbase + DOC_W'(ofs_rd);
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_node_count   <= '0;
            r_cursor_node  <= '0;
            r_cursor_entry <= '0;
            r_valid        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_node_count   <= n_node_count;
            r_cursor_node  <= n_cursor_node;
            r_cursor_entry <= n_cursor_entry;
            r_valid        <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_doc      <= n_doc;
        r_di       <= n_di;
        r_ce       <= n_ce;
        r_i        <= n_i;
        r_prevbase <= n_prevbase;
        r_prevfill <= n_prevfill;
        r_nextbase <= n_nextbase;
        r_found    <= n_found;
        r_status   <= n_status;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_found_doc = r_found;
    assign o_status    = r_status;

`include "posting_block_skip_index_core_macros.svh"

    `PBSI_ASSERT_NEXT(a_start_progress, i_start && !o_busy, o_busy || o_valid, "start lost")
    `PBSI_ASSERT_NOW(a_valid_idle, o_valid, !o_busy, "result strobed while busy")
    `PBSI_ASSERT_NOW(a_count_range, 1'b1, r_node_count <= CW'(NODES), "node count overflow")
    `PBSI_ASSERT_NOW(a_cursor_range, !o_busy,
        (r_cursor_node < r_node_count) || (r_cursor_node == '0), "cursor beyond store")
endmodule
